>>> rtl/lab_pkg.sv
// Shared types, constants and the gamma decode table of the sRGB to CIELAB converter.
// Used by every module under rtl but lab_checker; depends on nothing else.
`default_nettype none

package lab_pkg;

  localparam int NLANE   = 3;   // X, Y, Z (or R, G, B on the input side)
  localparam int Q_W     = 31;  // unsigned Q30 values up to just below 2.0
  localparam int SUM_W   = 44;  // matrix sums, 14-bit coefficient times Q30
  localparam int NUM_W   = 47;  // rounded numerator ahead of white point division
  localparam int SPLIT_W = 23;  // low part of the numerator for the split multiply
  localparam int SQ_W    = 62;  // exact square of a cube root candidate
  localparam int ROOT_STEPS = 31;
  localparam int LNUM_W  = 38;  // 116 * fy
  localparam int MAG_W   = 31;

  typedef logic [Q_W-1:0] q30_t;
  typedef logic [NLANE-1:0][Q_W-1:0] q30_vec_t;
  typedef logic [NLANE-1:0][SUM_W-1:0] sum_vec_t;
  typedef logic [13:0] coef_t;
  typedef logic [Q_W-1:0] gamma_tbl_t [256];

  // sRGB D65 to XYZ, scaled by 10000
  localparam coef_t MATRIX [3][3] = '{
    '{14'd4124, 14'd3576, 14'd1805},
    '{14'd2126, 14'd7152, 14'd722},
    '{14'd193,  14'd1192, 14'd9505}
  };

  // White point division: q = (sum * NORM_MUL + DIVISOR/2) / DIVISOR
  localparam logic [16:0] DIVISOR [3] = '{17'd95047, 17'd10000, 17'd108883};
  localparam logic [3:0] NORM_MUL [3] = '{4'd10, 4'd1, 4'd10};
  localparam int RECIP_SHIFT [3] = '{47, 44, 47};
  localparam logic [30:0] NORM_RECIP [3] = '{
    31'((64'd1 << 47) / 64'd95047),
    31'((64'd1 << 44) / 64'd10000),
    31'((64'd1 << 47) / 64'd108883)
  };

  // Lab function, linear segment: round(t * 7.787) + 16/116
  localparam q30_t LIN_T_MAX    = 31'((64'd8856 << 30) / 64'd1000000);
  localparam logic [12:0] LIN_GAIN = 13'd7787;
  localparam logic [9:0] LIN_DIV   = 10'd1000;
  localparam int LIN_X_W       = 37;
  localparam int LIN_SHIFT     = 37;
  localparam logic [27:0] LIN_RECIP = 28'((64'd1 << 37) / 64'd1000);
  localparam q30_t LIN_OFS      = 31'(((64'd16 << 30) + 64'd58) / 64'd116);

  // Output scaling
  localparam logic [LNUM_W-1:0] L_OFS = LNUM_W'(64'd16 << 30);
  localparam logic [15:0] L_MAX = 16'd25600;
  localparam logic [8:0] A_SCALE = 9'd500;
  localparam logic [8:0] B_SCALE = 9'd200;

  function automatic gamma_tbl_t gamma_build();
    gamma_tbl_t tbl;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] res;
    logic [63:0] cand;
    logic [63:0] c2;
    logic [63:0] c4;
    logic [63:0] c5;
    for (int v = 0; v < 256; v++) begin
      if (v <= 10) begin
        tbl[v] = Q_W'((64'(v) * 64'd100 * (64'd1 << 30) + 64'd164730) / 64'd329460);
      end else begin
        u  = ((64'd1000 * 64'(v) + 64'd14025) * (64'd1 << 30) + 64'd134512) / 64'd269025;
        u2 = (u * u) >> 30;
        res = '0;
        // fifth root of u^2 by bit search, gives u^2.4 = u^2 * (u^2)^0.2
        for (int bt = 30; bt >= 0; bt--) begin
          cand = res | (64'd1 << bt);
          c2 = (cand * cand) >> 30;
          c4 = (c2 * c2) >> 30;
          c5 = (c4 * cand) >> 30;
          if (cand <= (64'd1 << 30) && c5 <= u2) begin
            res = cand;
          end
        end
        tbl[v] = Q_W'((u2 * res) >> 30);
      end
    end
    return tbl;
  endfunction

  localparam gamma_tbl_t GAMMA_TBL = gamma_build();

endpackage

`default_nettype wire

>>> rtl/lab_gamma.sv
// Gamma decode table lookup and the RGB to XYZ matrix, two register stages.
// Depends on lab_pkg.
`default_nettype none

module lab_gamma (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_i,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output logic              valid_o,
  output lab_pkg::sum_vec_t sums
);
  import lab_pkg::*;

  logic [1:0] vld;
  q30_t lin [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], valid_i};
    end
  end

  assign valid_o = vld[1];

  always_ff @(posedge clk) begin
    if (en) begin
      lin[0] <= GAMMA_TBL[red];
      lin[1] <= GAMMA_TBL[green];
      lin[2] <= GAMMA_TBL[blue];
      for (int i = 0; i < NLANE; i++) begin
        sums[i] <= SUM_W'(MATRIX[i][0]) * SUM_W'(lin[0])
                 + SUM_W'(MATRIX[i][1]) * SUM_W'(lin[1])
                 + SUM_W'(MATRIX[i][2]) * SUM_W'(lin[2]);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/lab_norm.sv
// White point normalization: rounded division by a constant through a split
// reciprocal multiply and one correction step, four register stages.
// Depends on lab_pkg.
`default_nettype none

module lab_norm (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_i,
  input  lab_pkg::sum_vec_t sums,
  output logic              valid_o,
  output lab_pkg::q30_vec_t quot
);
  import lab_pkg::*;

  logic [3:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], valid_i};
    end
  end

  assign valid_o = vld[3];

  for (genvar ln = 0; ln < NLANE; ln++) begin : g_lane
    localparam int K = RECIP_SHIFT[ln];
    localparam int HI_W = NUM_W - SPLIT_W;
    localparam int PH_W = HI_W + Q_W;
    localparam int PL_W = SPLIT_W + Q_W;
    localparam int PS_W = PH_W + SPLIT_W;

    logic [NUM_W-1:0] num_a;
    logic [NUM_W-1:0] num_b;
    logic [NUM_W-1:0] num_c;
    logic [PH_W-1:0]  p_hi;
    logic [PL_W-1:0]  p_lo;
    logic [PS_W-1:0]  p_sum;
    logic [Q_W-1:0]   q0;
    logic [NUM_W:0]   rem;

    assign p_sum = {p_hi, SPLIT_W'(0)} + PS_W'(p_lo);
    // q0 is the quotient or one below it
    assign rem = {1'b0, num_c} - (NUM_W+1)'(q0) * (NUM_W+1)'(DIVISOR[ln]);

    always_ff @(posedge clk) begin
      if (en) begin
        num_a <= NUM_W'(sums[ln]) * NUM_W'(NORM_MUL[ln]) + NUM_W'(DIVISOR[ln] >> 1);
        p_hi  <= PH_W'(num_a[NUM_W-1:SPLIT_W]) * PH_W'(NORM_RECIP[ln]);
        p_lo  <= PL_W'(num_a[SPLIT_W-1:0]) * PL_W'(NORM_RECIP[ln]);
        num_b <= num_a;
        q0    <= p_sum[K +: Q_W];
        num_c <= num_b;
        quot[ln] <= (rem >= (NUM_W+1)'(DIVISOR[ln])) ? q0 + Q_W'(1) : q0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/lab_fcomp.sv
// CIELAB companding function per lane: a bit-per-stage cube root over 31 stages
// and the linear segment beside it. Depends on lab_pkg.
`default_nettype none

module lab_fcomp (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_i,
  input  lab_pkg::q30_vec_t t,
  output logic              valid_o,
  output lab_pkg::q30_vec_t f
);
  import lab_pkg::*;

  logic [ROOT_STEPS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROOT_STEPS-2:0], valid_i};
    end
  end

  assign valid_o = vld[ROOT_STEPS-1];

  for (genvar ln = 0; ln < NLANE; ln++) begin : g_lane
    localparam int LIN_LEN = ROOT_STEPS - 2;

    q30_t            res_s [ROOT_STEPS+1];
    q30_t            t_s   [ROOT_STEPS+1];
    logic [SQ_W-1:0] sq_s  [ROOT_STEPS];
    logic [SQ_W-1:0] sc_s  [ROOT_STEPS];

    logic [ROOT_STEPS-1:0]  big_sr;
    logic [LIN_X_W-1:0]     lx;
    logic [LIN_X_W-1:0]     lx2;
    logic [LIN_X_W+27:0]    lp;
    logic [27:0]            lq0;
    logic [LIN_X_W-1:0]     lrem;
    q30_t                   lin_sr [LIN_LEN];

    // start: result zero, first candidate 1.0 whose square is 2^60
    assign res_s[0] = '0;
    assign sq_s[0]  = '0;
    assign sc_s[0]  = SQ_W'(1) << 60;
    assign t_s[0]   = t[ln];

    for (genvar st = 0; st < ROOT_STEPS; st++) begin : g_step
      localparam int B = ROOT_STEPS - 1 - st;

      q30_t              cand;
      logic [2*Q_W:0]    prod;
      logic              acc;

      assign cand = res_s[st] | (Q_W'(1) << B);
      assign prod = (2*Q_W+1)'(sc_s[st][SQ_W-1:30]) * (2*Q_W+1)'(cand);
      assign acc  = prod[2*Q_W:30] <= (Q_W+2)'(t_s[st]);

      always_ff @(posedge clk) begin
        if (en) begin
          res_s[st+1] <= acc ? cand : res_s[st];
          t_s[st+1]   <= t_s[st];
        end
      end

      if (B > 0) begin : g_next
        logic [SQ_W-1:0] sa;
        logic [SQ_W-1:0] sb;
        // square of the next candidate for either outcome of this step
        assign sa = sc_s[st] + (SQ_W'(cand) << B) + (SQ_W'(1) << (2*B-2));
        assign sb = sq_s[st] + (SQ_W'(res_s[st]) << B) + (SQ_W'(1) << (2*B-2));

        always_ff @(posedge clk) begin
          if (en) begin
            sq_s[st+1] <= acc ? sc_s[st] : sq_s[st];
            sc_s[st+1] <= acc ? sa : sb;
          end
        end
      end
    end

    assign lq0  = lp[LIN_SHIFT +: 28];
    assign lrem = lx2 - LIN_X_W'(lq0) * LIN_X_W'(LIN_DIV);

    always_ff @(posedge clk) begin
      if (en) begin
        big_sr <= {big_sr[ROOT_STEPS-2:0], t[ln] > LIN_T_MAX};
        lx  <= LIN_X_W'(t[ln][23:0]) * LIN_X_W'(LIN_GAIN) + LIN_X_W'(LIN_DIV >> 1);
        lp  <= (LIN_X_W+28)'(lx) * (LIN_X_W+28)'(LIN_RECIP);
        lx2 <= lx;
        lin_sr[0] <= Q_W'(lq0) + Q_W'(lrem >= LIN_X_W'(LIN_DIV)) + LIN_OFS;
        for (int i = 1; i < LIN_LEN; i++) begin
          lin_sr[i] <= lin_sr[i-1];
        end
      end
    end

    assign f[ln] = big_sr[ROOT_STEPS-1] ? res_s[ROOT_STEPS] : lin_sr[LIN_LEN-1];
  end

endmodule

`default_nettype wire

>>> rtl/lab_out.sv
// Final L, a, b arithmetic: one register stage for the differences, then
// scaling, rounding and saturation. Depends on lab_pkg.
`default_nettype none

module lab_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_i,
  input  lab_pkg::q30_vec_t f,
  output logic              valid_o,
  output logic [14:0]       lightness,
  output logic [15:0]       green_red_axis,
  output logic [15:0]       blue_yellow_axis
);
  import lab_pkg::*;

  logic              vld;
  logic [LNUM_W-1:0] lnum;
  logic              neg_a;
  logic              neg_b;
  logic [MAG_W-1:0]  mag_a;
  logic [MAG_W-1:0]  mag_b;
  logic [LNUM_W-1:0] lsub;
  logic [15:0]       lv;

  function automatic logic [15:0] axis_sat(input logic [MAG_W-1:0] mag, input logic neg,
                                           input logic [8:0] scale);
    logic [MAG_W+8:0] prod;
    logic [17:0]      v;
    prod = (MAG_W+9)'(mag) * (MAG_W+9)'(scale) + (MAG_W+9)'(1 << 21);
    v = prod[MAG_W+8:22];
    if (neg) begin
      if (v > 18'd32768) begin
        v = 18'd32768;
      end
      return 16'(18'd0 - v);
    end
    if (v > 18'd32767) begin
      v = 18'd32767;
    end
    return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lnum  <= LNUM_W'(f[1]) * LNUM_W'(116);
      neg_a <= f[0] < f[1];
      mag_a <= (f[0] < f[1]) ? f[1] - f[0] : f[0] - f[1];
      neg_b <= f[1] < f[2];
      mag_b <= (f[1] < f[2]) ? f[2] - f[1] : f[1] - f[2];
    end
  end

  assign valid_o = vld;
  assign lsub = lnum - L_OFS + LNUM_W'(1 << 21);

  always_comb begin
    if (lnum <= L_OFS) begin
      lv = '0;
    end else begin
      lv = lsub[LNUM_W-1:22];
    end
    if (lv > L_MAX) begin
      lv = L_MAX;
    end
  end

  assign lightness        = lv[14:0];
  assign green_red_axis   = axis_sat(mag_a, neg_a, A_SCALE);
  assign blue_yellow_axis = axis_sat(mag_b, neg_b, B_SCALE);

endmodule

`default_nettype wire

>>> rtl/rgb_to_cielab_converter.sv
// sRGB (8 bits a channel) to CIELAB D65 converter.
// Channels: the input request carries red, green, blue with in_valid; it is
// taken at a rising edge where in_valid is high and in_stall is low. The result
// request carries lightness (unsigned Q8), green_red_axis and blue_yellow_axis
// (signed Q8, saturated) with out_valid; the receiver holds it with out_stall.
// Throughput: one pixel per clock while in_stall is low. The pipeline runs
// through the table and matrix, four division stages, the cube root, which
// resolves one bit per stage over 31 stages, and the output stages, and the
// result is finally loaded into the output register.
// The whole pipeline advances together while the skid register is empty.
// When the receiver stalls, the output register holds its request and the next
// result lands in the skid register; in_stall then rises and the pipeline
// holds until the output drains. Nothing is dropped or repeated.
// Reset (rst, synchronous) clears all valid bits; the data registers are not reset.
// Depends on lab_pkg, lab_gamma, lab_norm, lab_fcomp, lab_out.
`default_nettype none

module rgb_to_cielab_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] lightness,
  output logic [15:0] green_red_axis,
  output logic [15:0] blue_yellow_axis
);
  import lab_pkg::*;

  logic     pipe_en;
  logic     sum_valid;
  logic     norm_valid;
  logic     f_valid;
  logic     tail_valid;
  sum_vec_t sums;
  q30_vec_t tnorm;
  q30_vec_t fval;

  logic [14:0] tail_l;
  logic [15:0] tail_a;
  logic [15:0] tail_b;

  logic        skid_valid;
  logic [14:0] skid_l;
  logic [15:0] skid_a;
  logic [15:0] skid_b;
  logic        take;
  logic        load_out;
  logic        load_skid;

  assign pipe_en  = ~skid_valid;
  assign in_stall = skid_valid;

  lab_gamma u_gamma (
    .clk     (clk),
    .rst     (rst),
    .en      (pipe_en),
    .valid_i (in_valid),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .valid_o (sum_valid),
    .sums    (sums)
  );

  lab_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (pipe_en),
    .valid_i (sum_valid),
    .sums    (sums),
    .valid_o (norm_valid),
    .quot    (tnorm)
  );

  lab_fcomp u_fcomp (
    .clk     (clk),
    .rst     (rst),
    .en      (pipe_en),
    .valid_i (norm_valid),
    .t       (tnorm),
    .valid_o (f_valid),
    .f       (fval)
  );

  lab_out u_out (
    .clk              (clk),
    .rst              (rst),
    .en               (pipe_en),
    .valid_i          (f_valid),
    .f                (fval),
    .valid_o          (tail_valid),
    .lightness        (tail_l),
    .green_red_axis   (tail_a),
    .blue_yellow_axis (tail_b)
  );

  assign take      = out_valid & ~out_stall;
  assign load_out  = pipe_en & tail_valid & (~out_valid | take);
  assign load_skid = pipe_en & tail_valid & out_valid & ~take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // drain the skid register into the output
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (load_skid) begin
      skid_valid <= 1'b1;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        lightness        <= skid_l;
        green_red_axis   <= skid_a;
        blue_yellow_axis <= skid_b;
      end
    end else if (load_out) begin
      lightness        <= tail_l;
      green_red_axis   <= tail_a;
      blue_yellow_axis <= tail_b;
    end
    if (load_skid) begin
      skid_l <= tail_l;
      skid_a <= tail_a;
      skid_b <= tail_b;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lab_checker.sv
// Port-level checks on the converter's result channel and flow control,
// bound to rgb_to_cielab_converter. Depends on nothing else.
`default_nettype none

module lab_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [14:0] lightness,
  input wire [15:0] green_red_axis,
  input wire [15:0] blue_yellow_axis
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result request present right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result request dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(lightness) && $stable(green_red_axis)
                              && $stable(blue_yellow_axis))
    else $error("stalled result request changed");

  a_l_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lightness <= 15'd25600)
    else $error("lightness above 100");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    !out_valid |=> !in_stall)
    else $error("input stalled while the output was empty");

endmodule

bind rgb_to_cielab_converter lab_checker u_lab_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .lightness        (lightness),
  .green_red_axis   (green_red_axis),
  .blue_yellow_axis (blue_yellow_axis)
);

`default_nettype wire
